// ===== sv/hsf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the HDLC zero-stuffing FM0 line encoder.
// No dependencies; imported by every module of the encoder.
package hsf_pkg;

	// Width of the byte field on the input stream.
	localparam int DATA_IN_W = 8;

	// Default number of data bits sent per accepted beat.
	localparam int BYTE_BITS_DEF = 8;

	// Width of the consecutive-ones counter and its saturation value.
	localparam int RUN_W = 3;
	localparam logic [RUN_W-1:0] RUN_MAX = 3'd7;

	// A one that brings the run to this count is followed by a stuffed zero.
	localparam logic [RUN_W-1:0] STUFF_RUN = 3'd5;

	// Most half cells delivered for one byte; further halves are dropped.
	localparam int MAX_HALVES = 20;
	localparam int HALF_CNT_W = $clog2(MAX_HALVES + 1);
	localparam logic [HALF_CNT_W-1:0] MAX_HALVES_C = HALF_CNT_W'(MAX_HALVES);

	// One half cell on its way from the serializer to the output register.
	typedef struct packed {
		logic level;
		logic stuffed;
		logic last;
	} half_t;

endpackage

// ===== sv/hsf_serializer.sv =====
`timescale 1ns / 1ps
// Bit-serial FM0 core: shifts the byte out LSB first, tracks the ones run,
// inserts stuffed zero cells; one half-cell level per cycle unless stalled.
// Depends on hsf_pkg.
module hsf_serializer #(
	parameter int BYTE_BITS = hsf_pkg::BYTE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  logic [hsf_pkg::DATA_IN_W-1:0]   data_byte,
	input  logic                            stuff_enable,
	output logic                            busy,
	input  logic                            out_ready,
	output logic                            half_valid,
	output hsf_pkg::half_t                  half
);
	import hsf_pkg::*;

	localparam int REM_W = $clog2(BYTE_BITS + 1);

	logic [BYTE_BITS-1:0]  data_q;
	logic [BYTE_BITS-1:0]  load_bits;
	logic [REM_W-1:0]      rem_q;
	logic [RUN_W-1:0]      run_q;
	logic [RUN_W-1:0]      run_inc;
	logic [HALF_CNT_W-1:0] halves_q;
	logic                  line_q;
	logic                  phase_q;
	logic                  stuff_cell_q;
	logic                  stuff_en_q;
	logic                  busy_q;
	logic                  cur_one;
	logic                  lvl_next;
	logic                  go_stuff;
	logic                  final_half;
	logic                  step;

	// Byte bits beyond the input field read as zero.
	for (genvar i = 0; i < BYTE_BITS; i++) begin : g_load
		if (i < DATA_IN_W) begin : g_data
			assign load_bits[i] = data_byte[i];
		end else begin : g_zero
			assign load_bits[i] = 1'b0;
		end
	end

	// Level of the current half cell and the stuffing decision for this bit.
	always_comb begin
		cur_one    = !stuff_cell_q && data_q[0];
		lvl_next   = (phase_q && cur_one) ? line_q : ~line_q;
		run_inc    = (run_q < RUN_MAX) ? run_q + RUN_W'(1) : run_q;
		go_stuff   = !stuff_cell_q && data_q[0] && stuff_en_q && (run_inc >= STUFF_RUN);
		final_half = phase_q && (stuff_cell_q ? (rem_q == REM_W'(0))
		                                      : ((rem_q == REM_W'(1)) && !go_stuff));
		step       = busy_q && out_ready;
	end

	// Half cell offered to the output register; overflow halves are dropped.
	always_comb begin
		half_valid   = step && (halves_q < MAX_HALVES_C);
		half.level   = lvl_next;
		half.stuffed = stuff_cell_q;
		half.last    = final_half || (halves_q == MAX_HALVES_C - HALF_CNT_W'(1));
	end

	assign busy = busy_q;

	// Control state: line level and ones run persist across bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q       <= 1'b1;
			run_q        <= '0;
			phase_q      <= 1'b0;
			stuff_cell_q <= 1'b0;
			stuff_en_q   <= 1'b0;
			busy_q       <= 1'b0;
			rem_q        <= '0;
			halves_q     <= '0;
		end else if (load) begin
			phase_q      <= 1'b0;
			stuff_cell_q <= 1'b0;
			stuff_en_q   <= stuff_enable;
			busy_q       <= 1'b1;
			rem_q        <= REM_W'(BYTE_BITS);
			halves_q     <= '0;
		end else if (step) begin
			line_q  <= lvl_next;
			phase_q <= ~phase_q;
			if (halves_q < MAX_HALVES_C) begin
				halves_q <= halves_q + HALF_CNT_W'(1);
			end
			if (phase_q) begin
				if (stuff_cell_q) begin
					stuff_cell_q <= 1'b0;
				end else begin
					rem_q        <= rem_q - REM_W'(1);
					stuff_cell_q <= go_stuff;
					if (!data_q[0] || go_stuff) begin
						run_q <= '0;
					end else begin
						run_q <= run_inc;
					end
				end
			end
			if (final_half) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Data shift register; advances after the second half of each data cell.
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_bits;
		end else if (step && phase_q && !stuff_cell_q) begin
			data_q <= data_q >> 1;
		end
	end

endmodule

// ===== sv/hsf_out_reg.sv =====
`timescale 1ns / 1ps
// Output register that holds one half-cell beat until the sink takes it.
// Depends on hsf_pkg.
module hsf_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  hsf_pkg::half_t in_half,
	output logic           can_take,
	output logic           out_valid,
	input  logic           out_ready,
	output hsf_pkg::half_t out_half
);
	import hsf_pkg::*;

	logic  valid_q;
	half_t half_q;

	// Room for a new beat when empty or when the held beat leaves now.
	assign can_take  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_half  = half_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && in_valid) begin
			half_q <= in_half;
		end
	end

endmodule

// ===== sv/hdlc_stuff_fm0_encoder_top.sv =====
`timescale 1ns / 1ps
// HDLC zero-stuffing FM0 encoder, top level. Depends on hsf_pkg, hsf_serializer, hsf_out_reg.
// Path: a byte beat loads the serializer; each half cell is then held in the output register.
// Throughput: one half cell per cycle while the sink keeps up; a byte gives 2 * (BYTE_BITS +
// stuffed cells) half cells, at most MAX_HALVES; the next byte waits for an idle serializer.
// Reset: asynchronous, active low; the line level starts high and the ones run at zero.
module hdlc_stuff_fm0_encoder_top #(
	parameter int BYTE_BITS = hsf_pkg::BYTE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic [0:0] s_axis_tuser,   // [0] stuff_enable
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [0] half_level, [7:1] zero
	output logic [0:0] m_axis_tuser,   // [0] stuffed_cell
	output logic       m_axis_tlast    // last half cell of the byte
);
	import hsf_pkg::*;

	logic  busy;
	logic  load;
	logic  can_take;
	logic  half_valid;
	half_t half;
	half_t out_half;

	// A new byte is taken only while the serializer is idle.
	assign s_axis_tready = !busy;
	assign load          = s_axis_tvalid && !busy;

	hsf_serializer #(
		.BYTE_BITS(BYTE_BITS)
	) u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.data_byte   (s_axis_tdata[DATA_IN_W-1:0]),
		.stuff_enable(s_axis_tuser[0]),
		.busy        (busy),
		.out_ready   (can_take),
		.half_valid  (half_valid),
		.half        (half)
	);

	hsf_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (half_valid),
		.in_half  (half),
		.can_take (can_take),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_half (out_half)
	);

	// Pack the held beat onto the master side.
	assign m_axis_tdata = {7'd0, out_half.level};
	assign m_axis_tuser = out_half.stuffed;
	assign m_axis_tlast = out_half.last;

endmodule

// ===== tb/fm0_line_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the HDLC zero-stuffing FM0 encoder: predicts the half cells of every byte beat.
// Depends on hsf_pkg; instantiated beside the encoder by tb_hdlc_stuff_fm0_encoder_top.
module fm0_line_checker #(
	parameter int BYTE_BITS = hsf_pkg::BYTE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic [0:0] s_axis_tuser,   // [0] stuff_enable
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,   // [0] half_level, [7:1] zero
	input  logic [0:0] m_axis_tuser,   // [0] stuffed_cell
	input  logic       m_axis_tlast,
	output int         fail_count,
	output int         pending
);

	// Half cells still owed by the encoder, oldest first.
	hsf_pkg::half_t exp_halves[$];

	// Predicted line state and the ones run carried across bytes.
	logic                       line_q;
	logic [hsf_pkg::RUN_W-1:0]  ones_q;
	int                         byte_halves;

	// Queue one half cell unless the per-byte limit is already reached.
	task automatic push_half(input logic level, input logic stuffed);
		hsf_pkg::half_t h;
		if (byte_halves < hsf_pkg::MAX_HALVES) begin
			h.level   = level;
			h.stuffed = stuffed;
			h.last    = 1'b0;
			exp_halves.push_back(h);
			byte_halves++;
		end
	endtask

	// An FM0 cell toggles at its start; a zero toggles again at mid-cell.
	task automatic push_cell(input logic one, input logic stuffed);
		line_q = ~line_q;
		push_half(line_q, stuffed);
		if (!one)
			line_q = ~line_q;
		push_half(line_q, stuffed);
	endtask

	// Expand one byte, LSB first, inserting a zero cell after a run of ones when stuffing is enabled.
	task automatic encode_byte(input logic [7:0] data, input logic stuff);
		hsf_pkg::half_t h;
		logic [63:0]    wide;
		logic           one;
		wide        = 64'(data);
		byte_halves = 0;
		for (int i = 0; i < BYTE_BITS; i++) begin
			one = wide[i];
			push_cell(one, 1'b0);
			if (one) begin
				if (ones_q < hsf_pkg::RUN_MAX)
					ones_q = ones_q + 1'b1;
				if (stuff && ones_q >= hsf_pkg::STUFF_RUN) begin
					push_cell(1'b0, 1'b1);
					ones_q = '0;
				end
			end else begin
				ones_q = '0;
			end
		end
		// The final kept half of the byte carries the last flag.
		if (byte_halves > 0) begin
			h = exp_halves[exp_halves.size() - 1];
			h.last = 1'b1;
			exp_halves[exp_halves.size() - 1] = h;
		end
	endtask

	// Predict on every input beat, then compare every output beat.
	always @(posedge clk or negedge arst_n) begin : monitor
		hsf_pkg::half_t want;
		if (!arst_n) begin
			exp_halves.delete();
			line_q     = 1'b1;
			ones_q     = '0;
			fail_count = 0;
			pending    = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				encode_byte(s_axis_tdata, s_axis_tuser[0]);
			if (m_axis_tvalid && m_axis_tready) begin
				if (exp_halves.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected half cell, got tdata=%h stuffed=%b last=%b",
						$time, m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
				end else begin
					want = exp_halves.pop_front();
					if (m_axis_tdata !== {7'd0, want.level} ||
							m_axis_tuser[0] !== want.stuffed ||
							m_axis_tlast !== want.last) begin
						fail_count++;
						$display("%0t: half cell mismatch, expected tdata=%h stuffed=%b last=%b,",
							$time, {7'd0, want.level}, want.stuffed, want.last);
						$display("%0t:   got tdata=%h stuffed=%b last=%b",
							$time, m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
					end
				end
			end
			pending = exp_halves.size();
		end
	end

endmodule

// ===== tb/tb_hdlc_stuff_fm0_encoder_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the HDLC zero-stuffing FM0 encoder: clock, reset, byte and ready stimulus.
// Depends on hsf_pkg, hdlc_stuff_fm0_encoder_top and fm0_line_checker.
module tb_hdlc_stuff_fm0_encoder_top;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [7:0] FLAG_BYTE = 8'h7E;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic [0:0] s_axis_tuser;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;
	logic       m_axis_tlast;

	int fail_count;
	int pending;
	int stall_cycles = 0;
	int tx_idle_pct  = 24;
	int rx_idle_pct  = 51;
	bit hold_req     = 1'b0;

	// Directed beats as {stuff_enable, data_byte}: plain extremes, runs that reach the
	// stuffing limit inside and across bytes, a run saturated with stuffing off, and flag
	// or abort patterns sent without stuffing.
	logic [8:0] directed_beats [21] = '{
		9'h1_00, 9'h1_FF, 9'h0_FF, 9'h0_FF, 9'h1_01, 9'h1_1F, 9'h1_0F,
		9'h1_01, 9'h1_F8, 9'h1_FF, 9'h1_0F, 9'h1_3F, 9'h0_7E, 9'h0_FE,
		9'h0_7F, 9'h1_AA, 9'h1_55, 9'h1_80, 9'h0_FF, 9'h1_03, 9'h0_00
	};

	hdlc_stuff_fm0_encoder_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	fm0_line_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog on cycles in which neither side moves a beat.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Output ready: random stalls, plus one long hold-off when requested.
	initial begin
		int hold_left;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--)
					@(negedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// Offer one byte beat after random idle cycles and wait until it is taken.
	task automatic send_beat(input logic [7:0] data, input logic stuff);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= stuff;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// Random byte, biased toward long runs of ones so that stuffing happens often.
	task automatic send_random_beat();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick <= 3)
			send_beat(8'($urandom), 1'($urandom));
		else if (pick <= 6)
			send_beat(8'($urandom | $urandom), 1'b1);
		else if (pick == 7)
			send_beat(FLAG_BYTE, 1'b0);
		else if (pick == 8)
			send_beat(8'hFF, 1'($urandom));
		else
			send_beat(8'($urandom & $urandom), 1'b1);
	endtask

	// Reset, directed beats, three random phases, drain and verdict.
	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'd0;
		s_axis_tuser  = 1'b0;
		arst_n        = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_beats[k])
			send_beat(directed_beats[k][7:0], directed_beats[k][8]);
		repeat (36) send_random_beat();

		tx_idle_pct = 51;
		rx_idle_pct = 24;
		repeat (36) send_random_beat();

		// No idling; the output side first holds off long enough to back up the input.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req    = 1'b1;
		repeat (37) send_random_beat();

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== hdlc_stuff_fm0_encoder_top.f =====
sv/hsf_pkg.sv
sv/hsf_serializer.sv
sv/hsf_out_reg.sv
sv/hdlc_stuff_fm0_encoder_top.sv
tb/fm0_line_checker.sv
tb/tb_hdlc_stuff_fm0_encoder_top.sv
